>>> rtl/core/mpic_pkg.sv
// Shared widths, codes, coefficient tables and table-building functions for the pt correction.
package mpic_pkg;

    // Field widths
    localparam int D_W    = 18;
    localparam int P_W    = 16;
    localparam int ETA_W  = 12;
    localparam int OUT_W  = 18;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 2;

    // Datapath widths
    localparam int A_W    = 19;          // fit amplitude, Q16
    localparam int B_W    = 18;          // tanh slope, Q8
    localparam int C_W    = 27;          // linear term, Q16
    localparam int X_W    = 23;          // tanh argument, Q16
    localparam int F_W    = 19;          // interpolation fraction
    localparam int TQ_W   = 17;          // tanh value, Q16, up to 1.0
    localparam int CD_W   = C_W + D_W;   // c * |d0|
    localparam int PP_W   = 2 * P_W;     // pt squared
    localparam int AT_W   = A_W + TQ_W;  // a * tanh
    localparam int S_W    = CD_W;        // bracket sum, Q36
    localparam int S20_W  = S_W - 16;    // bracket rounded to Q20
    localparam int PR_W   = S20_W + PP_W;
    localparam int M_W    = 32;          // quotient by 2^30
    localparam int RECIP_SHIFT = 41;
    localparam int CORR_W = 2 * M_W - RECIP_SHIFT;
    localparam int R_W    = CORR_W + 2;
    localparam int PROD_W = TQ_W + F_W + 2;
    localparam int NUM_STAGES = 11;

    // Rounding and scaling constants
    localparam logic [B_W+D_W-1:0] X_RND      = (B_W+D_W)'(2048);
    localparam logic [S_W-1:0]     S_RND      = S_W'(32768);
    localparam logic [PR_W:0]      HALF_DEN   = (PR_W+1)'(64'd335544320000);
    localparam logic [M_W-1:0]     RECIP_625  = 32'd3518437209;
    localparam logic signed [PROD_W-1:0] INTERP_RND = PROD_W'(262144);
    localparam logic [TQ_W-1:0]    TANH_ONE   = 17'h10000;

    // Output limits
    localparam logic signed [OUT_W-1:0] OUT_MAX = 18'sh1FFFF;
    localparam logic signed [OUT_W-1:0] OUT_MIN = 18'sh20000;

    // |eta| bin edges (0.9 and 1.7 in units of 1/512)
    localparam logic [ETA_W-1:0] ETA_EDGE_INNER = 12'd460;
    localparam logic [ETA_W-1:0] ETA_EDGE_MID   = 12'd870;

    localparam logic [1:0] BIN_INNER  = 2'd0;
    localparam logic [1:0] BIN_MIDDLE = 2'd1;
    localparam logic [1:0] BIN_OUTER  = 2'd2;

    // Period codes
    localparam logic [1:0] PERIOD_NONE = 2'd0;
    localparam logic [1:0] PERIOD_2016 = 2'd1;
    localparam logic [1:0] PERIOD_2018 = 2'd3;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD_SELECT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_USE_BEAM_SPOT = 1'd1;

    // Coefficients by [period][bin]
    localparam logic [A_W-1:0] FIT_A [3][3] = '{
        '{19'd77529, 19'd145883, 19'd241697},
        '{19'd46203, 19'd55902,  19'd361628},
        '{19'd63504, 19'd96076,  19'd67109}
    };
    localparam logic [B_W-1:0] FIT_B [3][3] = '{
        '{18'd155190, 18'd97469,  18'd59894},
        '{18'd242929, 18'd187822, 18'd66578},
        '{18'd176827, 18'd135022, 18'd158410}
    };
    localparam logic [C_W-1:0] FIT_C [3][3] = '{
        '{27'd10717102, 27'd16018964, 27'd26100367},
        '{27'd26248479, 27'd44907889, 27'd18494259},
        '{27'd19299041, 27'd30943478, 27'd67207168}
    };
    localparam logic [C_W-1:0] BS_K [3][3] = '{
        '{27'd26957578, 27'd44131942, 27'd72024064},
        '{27'd38162924, 27'd63835341, 27'd82798182},
        '{27'd42653450, 27'd64773816, 27'd97294746}
    };

    localparam logic [63:0] Q30_ONE = 64'd1 << 30;

    // Side data that travels alongside the tanh evaluation
    typedef struct packed {
        logic [A_W-1:0]  a;
        logic [CD_W-1:0] cd;
        logic [PP_W-1:0] pp;
        logic            neg;
        logic [P_W-1:0]  p;
    } side_t;

    // Correction magnitude with its sign and the original pt
    typedef struct packed {
        logic [CORR_W-1:0] corr;
        logic              neg;
        logic [P_W-1:0]    p;
    } scaled_t;

    // Restoring long division, used only while building constant tables
    function automatic logic [63:0] const_div(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] quo;
        logic [64:0] rem;
        quo = '0;
        rem = '0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[63:0], num[i]};
            if (rem >= {1'b0, den}) begin
                rem    = rem - {1'b0, den};
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Table point idx of n: round(2^16 * tanh(8*idx/n)), via exp series and squarings
    function automatic logic [TQ_W-1:0] tanh_point(input int unsigned idx, input int unsigned n);
        logic [63:0] y;
        logic [63:0] t;
        logic [63:0] e;
        logic [63:0] den;
        logic [63:0] quo;
        logic signed [63:0] sum;
        y   = const_div(64'(idx) << 28, 64'(n));
        t   = Q30_ONE;
        sum = $signed(Q30_ONE);
        for (int k = 1; k <= 12; k++) begin
            t = const_div((t * y) >> 30, 64'(k));
            if (k[0]) begin
                sum = sum - $signed(t);
            end else begin
                sum = sum + $signed(t);
            end
        end
        e = (sum > 0) ? $unsigned(sum) : 64'd0;
        for (int k = 0; k < 6; k++) begin
            e = (e * e + (Q30_ONE >> 1)) >> 30;
        end
        if (e > Q30_ONE) begin
            e = Q30_ONE;
        end
        den = Q30_ONE + e;
        quo = const_div(((Q30_ONE - e) << 16) + (den >> 1), den);
        return quo[TQ_W-1:0];
    endfunction

endpackage

>>> rtl/core/muon_pt_impact_correction.sv
// Top level of the muon pt correction from the charge-signed impact parameter.
//
// Usage:
//   Input channel (in_valid/in_ready) carries impact_signed, momentum_in and
//   pseudorapidity; output channel (out_valid/out_ready) returns momentum_out
//   and saturated, exactly one result per input, in order.
//   Configuration: cfg_write with cfg_index 0 sets period_select (0 passes pt
//   through), index 1 sets use_beam_spot. Write only while no item is in flight.
//   Throughput: one item per clock unless stalled, set by the eleven-stage pipeline
//   (no stage is more than one multiplier deep; the tanh table is read in one stage).
//   Depth: eleven register stages; the input is taken into the first and the
//   result is shown from the last.
//   Stall: each stage advances when it is empty or the one after it advances,
//   so bubbles close up and inputs are taken while a result waits; when every
//   stage is full and out_ready is low, in_ready drops and all data holds.
//   Reset: rst_n clears the stage valid bits and both configuration registers;
//   the tanh table is constant and needs no fill.
module muon_pt_impact_correction #(
    parameter int TANH_TABLE_ENTRIES = 256
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic signed [mpic_pkg::D_W-1:0]        impact_signed,
    input  logic [mpic_pkg::P_W-1:0]               momentum_in,
    input  logic signed [mpic_pkg::ETA_W-1:0]      pseudorapidity,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [mpic_pkg::OUT_W-1:0]      momentum_out,
    output logic                                   saturated,
    input  logic                                   cfg_write,
    input  logic [mpic_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [mpic_pkg::CFG_DATA_W-1:0]        cfg_data
);

    localparam int NS = mpic_pkg::NUM_STAGES;

    logic [NS-1:0]               valid_reg;
    logic [NS-1:0]               valid_next;
    logic [NS-1:0]               stage_en;
    logic [1:0]                  period_select_reg;
    logic                        use_beam_spot_reg;

    logic [mpic_pkg::X_W-1:0]    x_arg;
    mpic_pkg::side_t             side_front;
    logic [mpic_pkg::TQ_W-1:0]   tanh_val;
    mpic_pkg::side_t             side_tanh;
    mpic_pkg::scaled_t           scaled;

    logic signed [mpic_pkg::R_W-1:0]   r_val;
    logic                              in_range;
    logic signed [mpic_pkg::OUT_W-1:0] momentum_next;
    logic                              saturated_next;
    logic signed [mpic_pkg::OUT_W-1:0] momentum_out_reg;
    logic                              saturated_reg;

    // Advance a stage when it or any stage after it is empty, or the output is taken
    for (genvar g = 0; g < NS; g++) begin : g_en
        assign stage_en[g] = out_ready || !(&valid_reg[NS-1:g]);
    end

    always_comb
    begin
        valid_next[0] = stage_en[0] ? in_valid : valid_reg[0];
        for (int i = 1; i < NS; i++) begin
            valid_next[i] = stage_en[i] ? valid_reg[i-1] : valid_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            period_select_reg <= mpic_pkg::PERIOD_NONE;
            use_beam_spot_reg <= 1'b0;
        end else if (cfg_write) begin
            case (cfg_index)
                mpic_pkg::REG_PERIOD_SELECT: period_select_reg <= cfg_data;
                mpic_pkg::REG_USE_BEAM_SPOT: use_beam_spot_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    mpic_front u_front (
        .clk            (clk),
        .stage_en       (stage_en[1:0]),
        .period_select  (period_select_reg),
        .use_beam_spot  (use_beam_spot_reg),
        .impact_signed  (impact_signed),
        .momentum_in    (momentum_in),
        .pseudorapidity (pseudorapidity),
        .x_arg          (x_arg),
        .side           (side_front)
    );

    mpic_tanh #(
        .TABLE_ENTRIES (TANH_TABLE_ENTRIES)
    ) u_tanh (
        .clk      (clk),
        .stage_en (stage_en[4:2]),
        .x_arg    (x_arg),
        .side_in  (side_front),
        .tanh_val (tanh_val),
        .side_out (side_tanh)
    );

    mpic_scale u_scale (
        .clk      (clk),
        .stage_en (stage_en[9:5]),
        .tanh_val (tanh_val),
        .side_in  (side_tanh),
        .scaled   (scaled)
    );

    // Final stage: apply the signed correction and clip to the output range
    always_comb
    begin
        if (scaled.neg) begin
            r_val = $signed(mpic_pkg::R_W'(scaled.p)) + $signed(mpic_pkg::R_W'(scaled.corr));
        end else begin
            r_val = $signed(mpic_pkg::R_W'(scaled.p)) - $signed(mpic_pkg::R_W'(scaled.corr));
        end
        in_range = (r_val[mpic_pkg::R_W-1:mpic_pkg::OUT_W-1] == '0)
                   || (r_val[mpic_pkg::R_W-1:mpic_pkg::OUT_W-1] == '1);
        if (in_range) begin
            momentum_next  = r_val[mpic_pkg::OUT_W-1:0];
            saturated_next = 1'b0;
        end else begin
            momentum_next  = r_val[mpic_pkg::R_W-1] ? mpic_pkg::OUT_MIN : mpic_pkg::OUT_MAX;
            saturated_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[NS-1]) begin
            momentum_out_reg <= momentum_next;
            saturated_reg    <= saturated_next;
        end
    end

    assign in_ready     = stage_en[0];
    assign out_valid    = valid_reg[NS-1];
    assign momentum_out = momentum_out_reg;
    assign saturated    = saturated_reg;

    // An empty stage anywhere must leave room for a transfer in
    assert property (@(posedge clk) disable iff (!rst_n)
        !(&valid_reg) |-> in_ready)
        else $error("input blocked while the pipeline has an empty stage");

    // An accepted item must occupy the first stage
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> valid_reg[0])
        else $error("accepted item not captured in the first stage");

    // A delivered result with nothing behind it must not be shown again
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !valid_reg[NS-2] |=> !out_valid)
        else $error("result repeated after transfer out");

    // A clipped result sits at one of the limits
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && saturated |->
            (momentum_out == mpic_pkg::OUT_MAX) || (momentum_out == mpic_pkg::OUT_MIN))
        else $error("saturated flag set with an unclipped value");

endmodule

>>> rtl/core/mpic_front.sv
// Front stages: decode |d0| and |eta| bin, pick coefficients, form tanh argument, c*|d0| and pt^2.
module mpic_front (
    input  logic                          clk,
    input  logic [1:0]                    stage_en,
    input  logic [1:0]                    period_select,
    input  logic                          use_beam_spot,
    input  logic signed [mpic_pkg::D_W-1:0]   impact_signed,
    input  logic [mpic_pkg::P_W-1:0]          momentum_in,
    input  logic signed [mpic_pkg::ETA_W-1:0] pseudorapidity,
    output logic [mpic_pkg::X_W-1:0]      x_arg,
    output mpic_pkg::side_t               side
);

    logic [mpic_pkg::D_W-1:0]   d_bits;
    logic [mpic_pkg::ETA_W-1:0] eta_bits;
    logic [mpic_pkg::D_W-1:0]   dmag;
    logic [mpic_pkg::ETA_W-1:0] eta_mag;
    logic [1:0]                 bin;
    logic [1:0]                 per_idx;
    logic [mpic_pkg::A_W-1:0]   a_next;
    logic [mpic_pkg::B_W-1:0]   b_next;
    logic [mpic_pkg::C_W-1:0]   c_next;

    logic [mpic_pkg::D_W-1:0]   dmag_s1_reg;
    logic                       neg_s1_reg;
    logic [mpic_pkg::A_W-1:0]   a_s1_reg;
    logic [mpic_pkg::B_W-1:0]   b_s1_reg;
    logic [mpic_pkg::C_W-1:0]   c_s1_reg;
    logic [mpic_pkg::P_W-1:0]   p_s1_reg;

    logic [mpic_pkg::B_W+mpic_pkg::D_W-1:0] bd_sum;
    logic [mpic_pkg::X_W-1:0]   x_s2_reg;
    mpic_pkg::side_t            side_s2_reg;
    mpic_pkg::side_t            side_next;

    // Take magnitudes and select the |eta| bin
    always_comb
    begin
        d_bits   = impact_signed;
        eta_bits = pseudorapidity;
        dmag     = d_bits[mpic_pkg::D_W-1] ? (~d_bits + 1'b1) : d_bits;
        eta_mag  = eta_bits[mpic_pkg::ETA_W-1] ? (~eta_bits + 1'b1) : eta_bits;
        if (eta_mag <= mpic_pkg::ETA_EDGE_INNER) begin
            bin = mpic_pkg::BIN_INNER;
        end else if (eta_mag <= mpic_pkg::ETA_EDGE_MID) begin
            bin = mpic_pkg::BIN_MIDDLE;
        end else begin
            bin = mpic_pkg::BIN_OUTER;
        end
    end

    // Pick the coefficient set; no period zeroes every term
    always_comb
    begin
        per_idx = (period_select == mpic_pkg::PERIOD_NONE) ? 2'd0
                                                          : (period_select - mpic_pkg::PERIOD_2016);
        if (period_select == mpic_pkg::PERIOD_NONE) begin
            a_next = '0;
            b_next = '0;
            c_next = '0;
        end else if (use_beam_spot) begin
            a_next = '0;
            b_next = '0;
            c_next = mpic_pkg::BS_K[per_idx][bin];
        end else begin
            a_next = mpic_pkg::FIT_A[per_idx][bin];
            b_next = mpic_pkg::FIT_B[per_idx][bin];
            c_next = mpic_pkg::FIT_C[per_idx][bin];
        end
    end

    // Stage 1: hold decoded operands
    always_ff @(posedge clk)
    begin
        if (stage_en[0]) begin
            dmag_s1_reg <= dmag;
            neg_s1_reg  <= d_bits[mpic_pkg::D_W-1];
            a_s1_reg    <= a_next;
            b_s1_reg    <= b_next;
            c_s1_reg    <= c_next;
            p_s1_reg    <= momentum_in;
        end
    end

    // Stage 2 products: b*|d0| rounded to Q16, c*|d0|, pt^2
    always_comb
    begin
        bd_sum = (mpic_pkg::B_W+mpic_pkg::D_W)'(b_s1_reg * dmag_s1_reg) + mpic_pkg::X_RND;
        side_next.a   = a_s1_reg;
        side_next.cd  = mpic_pkg::CD_W'(c_s1_reg * dmag_s1_reg);
        side_next.pp  = mpic_pkg::PP_W'(p_s1_reg * p_s1_reg);
        side_next.neg = neg_s1_reg;
        side_next.p   = p_s1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[1]) begin
            x_s2_reg    <= bd_sum[mpic_pkg::X_W+11:12];
            side_s2_reg <= side_next;
        end
    end

    assign x_arg = x_s2_reg;
    assign side  = side_s2_reg;

endmodule

>>> rtl/core/mpic_tanh_rom.sv
// Constant tanh table split into even and odd points, with registered read of both halves.
module mpic_tanh_rom #(
    parameter int TABLE_ENTRIES = 256,
    localparam int EVEN_D = TABLE_ENTRIES / 2 + 1,
    localparam int ODD_D  = (TABLE_ENTRIES + 1) / 2,
    localparam int EA_W   = $clog2(EVEN_D),
    localparam int OA_W   = $clog2(ODD_D)
) (
    input  logic                         clk,
    input  logic                         rd_en,
    input  logic [EA_W-1:0]              even_addr,
    input  logic [OA_W-1:0]              odd_addr,
    output logic [mpic_pkg::TQ_W-1:0]    even_data,
    output logic [mpic_pkg::TQ_W-1:0]    odd_data
);

    logic [mpic_pkg::TQ_W-1:0] even_tab [EVEN_D];
    logic [mpic_pkg::TQ_W-1:0] odd_tab  [ODD_D];
    logic [mpic_pkg::TQ_W-1:0] even_data_reg;
    logic [mpic_pkg::TQ_W-1:0] odd_data_reg;

    // Build even points 0, 2, 4, ...
    for (genvar g = 0; g < EVEN_D; g++) begin : g_even
        localparam logic [mpic_pkg::TQ_W-1:0] POINT = mpic_pkg::tanh_point(2 * g, TABLE_ENTRIES);
        assign even_tab[g] = POINT;
    end

    // Build odd points 1, 3, 5, ...
    for (genvar g = 0; g < ODD_D; g++) begin : g_odd
        localparam logic [mpic_pkg::TQ_W-1:0] POINT =
            mpic_pkg::tanh_point(2 * g + 1, TABLE_ENTRIES);
        assign odd_tab[g] = POINT;
    end

    // Register both reads
    always_ff @(posedge clk)
    begin
        if (rd_en) begin
            even_data_reg <= even_tab[even_addr];
            odd_data_reg  <= odd_tab[odd_addr];
        end
    end

    assign even_data = even_data_reg;
    assign odd_data  = odd_data_reg;

endmodule

>>> rtl/core/mpic_tanh.sv
// Tanh stages: table index, table read and linear interpolation, with saturation to 1.0.
module mpic_tanh #(
    parameter int TABLE_ENTRIES = 256
) (
    input  logic                       clk,
    input  logic [2:0]                 stage_en,
    input  logic [mpic_pkg::X_W-1:0]   x_arg,
    input  mpic_pkg::side_t            side_in,
    output logic [mpic_pkg::TQ_W-1:0]  tanh_val,
    output mpic_pkg::side_t            side_out
);

    localparam int IDX_W  = $clog2(TABLE_ENTRIES);
    localparam int POS_W  = mpic_pkg::F_W + IDX_W;
    localparam int EVEN_D = TABLE_ENTRIES / 2 + 1;
    localparam int ODD_D  = (TABLE_ENTRIES + 1) / 2;
    localparam int EA_W   = $clog2(EVEN_D);
    localparam int OA_W   = $clog2(ODD_D);
    localparam int P_W2   = mpic_pkg::PROD_W;

    logic [POS_W-1:0]            pos;
    logic [IDX_W-1:0]            idx;
    logic [IDX_W:0]              idx_inc;
    logic [EA_W-1:0]             even_addr;
    logic [OA_W-1:0]             odd_addr;
    logic [mpic_pkg::TQ_W-1:0]   even_q;
    logic [mpic_pkg::TQ_W-1:0]   odd_q;

    logic                        idx_odd_s3_reg;
    logic [mpic_pkg::F_W-1:0]    frac_s3_reg;
    logic                        sat_s3_reg;
    mpic_pkg::side_t             side_s3_reg;

    logic [mpic_pkg::TQ_W-1:0]   t0;
    logic [mpic_pkg::TQ_W-1:0]   t1;
    logic signed [mpic_pkg::TQ_W:0]   diff;
    logic signed [mpic_pkg::F_W:0]    frac_s;
    logic signed [P_W2-1:0]      prod_next;
    logic signed [P_W2-1:0]      prod_s4_reg;
    logic [mpic_pkg::TQ_W-1:0]   t0_s4_reg;
    logic                        sat_s4_reg;
    mpic_pkg::side_t             side_s4_reg;

    logic signed [P_W2-1:0]      rnd_sum;
    logic signed [P_W2-1:0]      t_sum;
    logic [mpic_pkg::TQ_W-1:0]   tval_next;
    logic [mpic_pkg::TQ_W-1:0]   tval_s5_reg;
    mpic_pkg::side_t             side_s5_reg;

    // Split the argument into table index and fraction
    always_comb
    begin
        pos       = POS_W'(x_arg[mpic_pkg::F_W-1:0]) * POS_W'(TABLE_ENTRIES);
        idx       = pos[POS_W-1:mpic_pkg::F_W];
        idx_inc   = {1'b0, idx} + 1'b1;
        even_addr = idx_inc[EA_W:1];
        odd_addr  = idx[OA_W:1];
    end

    mpic_tanh_rom #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_rom (
        .clk       (clk),
        .rd_en     (stage_en[0]),
        .even_addr (even_addr),
        .odd_addr  (odd_addr),
        .even_data (even_q),
        .odd_data  (odd_q)
    );

    // Stage 3: hold fraction and saturation alongside the table read
    always_ff @(posedge clk)
    begin
        if (stage_en[0]) begin
            idx_odd_s3_reg <= idx[0];
            frac_s3_reg    <= pos[mpic_pkg::F_W-1:0];
            sat_s3_reg     <= (x_arg[mpic_pkg::X_W-1:mpic_pkg::F_W] != '0);
            side_s3_reg    <= side_in;
        end
    end

    // Stage 4: order the neighbours and scale their difference by the fraction
    always_comb
    begin
        t0        = idx_odd_s3_reg ? odd_q  : even_q;
        t1        = idx_odd_s3_reg ? even_q : odd_q;
        diff      = $signed({1'b0, t1}) - $signed({1'b0, t0});
        frac_s    = $signed({1'b0, frac_s3_reg});
        prod_next = diff * frac_s;
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[1]) begin
            prod_s4_reg <= prod_next;
            t0_s4_reg   <= t0;
            sat_s4_reg  <= sat_s3_reg;
            side_s4_reg <= side_s3_reg;
        end
    end

    // Stage 5: round the step and add it to the lower point
    always_comb
    begin
        rnd_sum   = prod_s4_reg + mpic_pkg::INTERP_RND;
        t_sum     = (rnd_sum >>> mpic_pkg::F_W)
                    + $signed({(P_W2-mpic_pkg::TQ_W)'(0), t0_s4_reg});
        tval_next = sat_s4_reg ? mpic_pkg::TANH_ONE : t_sum[mpic_pkg::TQ_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[2]) begin
            tval_s5_reg <= tval_next;
            side_s5_reg <= side_s4_reg;
        end
    end

    assign tanh_val = tval_s5_reg;
    assign side_out = side_s5_reg;

endmodule

>>> rtl/core/mpic_scale.sv
// Scaling stages: bracket sum, multiply by pt^2 and divide by 2^30 * 625 with rounding.
module mpic_scale (
    input  logic                       clk,
    input  logic [4:0]                 stage_en,
    input  logic [mpic_pkg::TQ_W-1:0]  tanh_val,
    input  mpic_pkg::side_t            side_in,
    output mpic_pkg::scaled_t          scaled
);

    logic [mpic_pkg::AT_W-1:0]    at_s6_reg;
    mpic_pkg::side_t              side_s6_reg;

    logic [mpic_pkg::S_W-1:0]     s_sum;
    logic [mpic_pkg::S20_W-1:0]   s20_s7_reg;
    logic [mpic_pkg::PP_W-1:0]    pp_s7_reg;
    logic                         neg_s7_reg;
    logic [mpic_pkg::P_W-1:0]     p_s7_reg;

    logic [mpic_pkg::PR_W-1:0]    pr_s8_reg;
    logic                         neg_s8_reg;
    logic [mpic_pkg::P_W-1:0]     p_s8_reg;

    logic [mpic_pkg::PR_W:0]      den_sum;
    logic [mpic_pkg::M_W-1:0]     m_s9_reg;
    logic                         neg_s9_reg;
    logic [mpic_pkg::P_W-1:0]     p_s9_reg;

    logic [2*mpic_pkg::M_W-1:0]   recip_prod;
    mpic_pkg::scaled_t            scaled_next;
    mpic_pkg::scaled_t            scaled_s10_reg;

    // Stage 6: a * tanh
    always_ff @(posedge clk)
    begin
        if (stage_en[0]) begin
            at_s6_reg   <= mpic_pkg::AT_W'(side_in.a * tanh_val);
            side_s6_reg <= side_in;
        end
    end

    // Stage 7: add the linear term and round the bracket to Q20
    always_comb
    begin
        s_sum = mpic_pkg::S_W'({at_s6_reg, 4'b0}) + side_s6_reg.cd + mpic_pkg::S_RND;
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[1]) begin
            s20_s7_reg <= s_sum[mpic_pkg::S_W-1:16];
            pp_s7_reg  <= side_s6_reg.pp;
            neg_s7_reg <= side_s6_reg.neg;
            p_s7_reg   <= side_s6_reg.p;
        end
    end

    // Stage 8: multiply by pt^2
    always_ff @(posedge clk)
    begin
        if (stage_en[2]) begin
            pr_s8_reg  <= mpic_pkg::PR_W'(s20_s7_reg * pp_s7_reg);
            neg_s8_reg <= neg_s7_reg;
            p_s8_reg   <= p_s7_reg;
        end
    end

    // Stage 9: add half the divisor and drop the 2^30 factor
    always_comb
    begin
        den_sum = {1'b0, pr_s8_reg} + mpic_pkg::HALF_DEN;
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[3]) begin
            m_s9_reg   <= den_sum[mpic_pkg::PR_W:30];
            neg_s9_reg <= neg_s8_reg;
            p_s9_reg   <= p_s8_reg;
        end
    end

    // Stage 10: divide by 625 through the reciprocal
    always_comb
    begin
        recip_prod       = (2*mpic_pkg::M_W)'(m_s9_reg * mpic_pkg::RECIP_625);
        scaled_next.corr = recip_prod[2*mpic_pkg::M_W-1:mpic_pkg::RECIP_SHIFT];
        scaled_next.neg  = neg_s9_reg;
        scaled_next.p    = p_s9_reg;
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[4]) begin
            scaled_s10_reg <= scaled_next;
        end
    end

    assign scaled = scaled_s10_reg;

endmodule

>>> tb/pt_correction_checker.sv
// Checker for the muon pt correction: watches the channels, predicts each corrected pt, compares.
`timescale 1ns / 100ps

module pt_correction_checker #(
    parameter int TABLE_POINTS = 256
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    input  logic                                   in_ready,
    input  logic signed [mpic_pkg::D_W-1:0]        impact_signed,
    input  logic [mpic_pkg::P_W-1:0]               momentum_in,
    input  logic signed [mpic_pkg::ETA_W-1:0]      pseudorapidity,
    input  logic                                   out_valid,
    input  logic                                   out_ready,
    input  logic signed [mpic_pkg::OUT_W-1:0]      momentum_out,
    input  logic                                   saturated,
    input  logic                                   cfg_write,
    input  logic [mpic_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [mpic_pkg::CFG_DATA_W-1:0]        cfg_data,
    output int                                     fails,
    output int                                     checked,
    output int                                     leftover
);

    localparam logic [63:0] ONE_Q30    = 64'd1 << 30;
    localparam logic [63:0] SCALE_DEN  = 64'd671088640000;
    localparam logic [63:0] TANH_SAT_X = 64'd8 << 16;
    localparam longint      PT_HI      = 131071;
    localparam longint      PT_LO      = -131072;
    localparam int          INNER_LIMIT  = 460;
    localparam int          MIDDLE_LIMIT = 870;
    localparam int          PRINT_LIMIT  = 50;

    typedef struct packed {
        logic signed [mpic_pkg::OUT_W-1:0] pt;
        logic                              clipped;
    } corrected_t;

    logic [16:0] tanh_lut [0:TABLE_POINTS];
    logic [1:0]  period_sel;
    logic        beam_spot;
    corrected_t  awaited_pt [$];

    // One point of the tanh table: exp(-16i/N) by series and squarings, then (1-E)/(1+E)
    function automatic logic [16:0] tanh_entry(input int unsigned i);
        logic [63:0] y;
        logic [63:0] t;
        logic [63:0] e;
        logic [63:0] q;
        longint      sum;
        y   = (64'(i) << 28) / 64'(TABLE_POINTS);
        t   = ONE_Q30;
        sum = longint'(ONE_Q30);
        for (int k = 1; k <= 12; k++)
        begin
            t = ((t * y) >> 30) / 64'(k);
            if (k % 2 == 1)
                sum = sum - longint'(t);
            else
                sum = sum + longint'(t);
        end
        e = (sum > 0) ? 64'(sum) : 64'd0;
        for (int k = 0; k < 6; k++)
            e = (e * e + (ONE_Q30 >> 1)) >> 30;
        if (e > ONE_Q30)
            e = ONE_Q30;
        q = (((ONE_Q30 - e) << 16) + ((ONE_Q30 + e) >> 1)) / (ONE_Q30 + e);
        return q[16:0];
    endfunction

    // Interpolated tanh of a non-negative Q16 argument; saturate to 1.0 past the table
    function automatic logic [63:0] tanh_q16(input logic [63:0] x);
        logic [63:0] pos;
        logic [63:0] idx;
        logic [63:0] frac;
        if (x >= TANH_SAT_X)
            return 64'd65536;
        pos  = x * 64'(TABLE_POINTS);
        idx  = pos >> 19;
        frac = pos & 64'h7FFFF;
        if (idx >= 64'(TABLE_POINTS))
            return 64'(tanh_lut[TABLE_POINTS]);
        return (64'(tanh_lut[idx]) * ((64'd1 << 19) - frac)
                + 64'(tanh_lut[idx + 1]) * frac + (64'd1 << 18)) >> 19;
    endfunction

    // Coefficients for period 0..2 (2016..2018) and eta bin: fit a, b, c and beam-spot k
    function automatic void pick_coeffs(input int per, input int bin,
                                        output logic [63:0] amp, output logic [63:0] slope,
                                        output logic [63:0] lin, output logic [63:0] beam);
        case (per * 3 + bin)
            0: begin amp = 77529;  slope = 155190; lin = 10717102; beam = 26957578; end
            1: begin amp = 145883; slope = 97469;  lin = 16018964; beam = 44131942; end
            2: begin amp = 241697; slope = 59894;  lin = 26100367; beam = 72024064; end
            3: begin amp = 46203;  slope = 242929; lin = 26248479; beam = 38162924; end
            4: begin amp = 55902;  slope = 187822; lin = 44907889; beam = 63835341; end
            5: begin amp = 361628; slope = 66578;  lin = 18494259; beam = 82798182; end
            6: begin amp = 63504;  slope = 176827; lin = 19299041; beam = 42653450; end
            7: begin amp = 96076;  slope = 135022; lin = 30943478; beam = 64773816; end
            default: begin amp = 67109; slope = 158410; lin = 67207168; beam = 97294746; end
        endcase
    endfunction

    // Corrected pt for one muon under the current period and mode
    function automatic corrected_t corrected_pt(input logic signed [mpic_pkg::D_W-1:0] d0,
                                                input logic [mpic_pkg::P_W-1:0] pt,
                                                input logic signed [mpic_pkg::ETA_W-1:0] eta);
        longint      d_l;
        longint      eta_l;
        longint      r;
        logic [63:0] dmag;
        logic [63:0] etamag;
        logic [63:0] amp;
        logic [63:0] slope;
        logic [63:0] lin;
        logic [63:0] beam;
        logic [63:0] arg;
        logic [63:0] brk;
        logic [63:0] corr;
        logic [1:0]  bin;
        corrected_t  res;
        d_l    = d0;
        eta_l  = eta;
        dmag   = 64'(d_l < 0 ? -d_l : d_l);
        etamag = 64'(eta_l < 0 ? -eta_l : eta_l);
        if (etamag <= 64'(INNER_LIMIT))
            bin = mpic_pkg::BIN_INNER;
        else if (etamag <= 64'(MIDDLE_LIMIT))
            bin = mpic_pkg::BIN_MIDDLE;
        else
            bin = mpic_pkg::BIN_OUTER;

        corr = '0;
        if (period_sel != mpic_pkg::PERIOD_NONE)
        begin
            pick_coeffs(int'(period_sel) - 1, int'(bin), amp, slope, lin, beam);
            if (beam_spot)
            begin
                amp   = '0;
                slope = '0;
                lin   = beam;
            end
            arg  = (slope * dmag + 64'd2048) >> 12;
            brk  = amp * tanh_q16(arg) * 64'd16 + lin * dmag;
            brk  = (brk + 64'd32768) >> 16;
            corr = (brk * 64'(pt) * 64'(pt) + (SCALE_DEN >> 1)) / SCALE_DEN;
        end

        // The correction carries the sign of d0
        r = longint'(pt) - (d_l < 0 ? -longint'(corr) : longint'(corr));
        res.clipped = 1'b0;
        if (r > PT_HI)
        begin
            r = PT_HI;
            res.clipped = 1'b1;
        end
        if (r < PT_LO)
        begin
            r = PT_LO;
            res.clipped = 1'b1;
        end
        res.pt = r[mpic_pkg::OUT_W-1:0];
        return res;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        if (fails < PRINT_LIMIT)
            $display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
        fails++;
    endtask

    // Build the tanh table once
    initial
    begin
        for (int i = 0; i <= TABLE_POINTS; i++)
            tanh_lut[i] = tanh_entry(i);
    end

    // Track configuration, queue predictions on input transfers, compare on output transfers
    always @(posedge clk or negedge rst_n)
    begin : watch
        corrected_t want;
        if (!rst_n)
        begin
            period_sel = mpic_pkg::PERIOD_NONE;
            beam_spot  = 1'b0;
            awaited_pt.delete();
            fails      = 0;
            checked   <= 0;
            leftover  <= 0;
        end
        else
        begin
            if (cfg_write)
            begin
                if (cfg_index == mpic_pkg::REG_PERIOD_SELECT)
                    period_sel = cfg_data[1:0];
                else if (cfg_index == mpic_pkg::REG_USE_BEAM_SPOT)
                    beam_spot = cfg_data[0];
            end
            if (in_valid && in_ready)
                awaited_pt.push_back(corrected_pt(impact_signed, momentum_in, pseudorapidity));
            if (out_valid && out_ready)
            begin
                if (awaited_pt.size() == 0)
                    report_mismatch("result with nothing outstanding", momentum_out, 0);
                else
                begin
                    want = awaited_pt.pop_front();
                    if (momentum_out !== want.pt)
                        report_mismatch("momentum_out", momentum_out, want.pt);
                    if (saturated !== want.clipped)
                        report_mismatch("saturated", saturated, want.clipped);
                end
                checked <= checked + 1;
            end
            leftover <= awaited_pt.size();
        end
    end

endmodule

>>> tb/tb.sv
// Testbench top for the muon pt correction: clock, reset, stimulus, stalls and verdict.
`timescale 1ns / 100ps

module tb;

    localparam int TABLE_POINTS = 256;
    localparam int QUIET_LIMIT  = 2000;
    localparam int LONG_HOLD    = 60;
    localparam int SETTLE       = 12;
    localparam int PHASES       = 12;
    localparam int PHASE_ITEMS  = 48;

    logic                                  clk;
    logic                                  rst_n;
    logic                                  in_valid;
    logic                                  in_ready;
    logic signed [mpic_pkg::D_W-1:0]       impact_signed;
    logic [mpic_pkg::P_W-1:0]              momentum_in;
    logic signed [mpic_pkg::ETA_W-1:0]     pseudorapidity;
    logic                                  out_valid;
    logic                                  out_ready;
    logic signed [mpic_pkg::OUT_W-1:0]     momentum_out;
    logic                                  saturated;
    logic                                  cfg_write;
    logic [mpic_pkg::CFG_IDX_W-1:0]        cfg_index;
    logic [mpic_pkg::CFG_DATA_W-1:0]       cfg_data;

    int   fails;
    int   checked;
    int   leftover;
    int   sent;
    int   hold_asks;
    int   quiet = 0;
    logic calm;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    muon_pt_impact_correction #(
        .TANH_TABLE_ENTRIES (TABLE_POINTS)
    ) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .impact_signed  (impact_signed),
        .momentum_in    (momentum_in),
        .pseudorapidity (pseudorapidity),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .momentum_out   (momentum_out),
        .saturated      (saturated),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    pt_correction_checker #(
        .TABLE_POINTS (TABLE_POINTS)
    ) pt_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .impact_signed  (impact_signed),
        .momentum_in    (momentum_in),
        .pseudorapidity (pseudorapidity),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .momentum_out   (momentum_out),
        .saturated      (saturated),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .fails          (fails),
        .checked        (checked),
        .leftover       (leftover)
    );

    // Stall length: mostly short, now and then long
    function automatic int stall_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 80)
            return $urandom_range(1, 3);
        else if (roll < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // Receiver: random back-pressure, a long hold when asked, none in calm phases
    initial
    begin : receiver
        int seen;
        seen      = 0;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (seen != hold_asks)
            begin
                seen = hold_asks;
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else if (calm || $urandom_range(0, 3) != 0)
            begin
                out_ready <= 1'b1;
                @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b0;
                repeat (stall_len()) @(posedge clk);
            end
        end
    end

    // Watchdog: end the run if nothing transfers for too long
    always @(posedge clk)
    begin
        if (!rst_n || cfg_write || (in_valid && in_ready) || (out_valid && out_ready))
            quiet <= 0;
        else if (quiet == QUIET_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
        else
            quiet <= quiet + 1;
    end

    task automatic set_mode(input logic [1:0] per, input logic [1:0] spot);
        cfg_write <= 1'b1;
        cfg_index <= mpic_pkg::REG_PERIOD_SELECT;
        cfg_data  <= per;
        @(posedge clk);
        cfg_index <= mpic_pkg::REG_USE_BEAM_SPOT;
        cfg_data  <= spot;
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    // Offer one muon, hold it until the transfer, then maybe leave a gap
    task automatic offer_muon(input int d0, input int pt, input int eta);
        int gap;
        in_valid       <= 1'b1;
        impact_signed  <= mpic_pkg::D_W'(d0);
        momentum_in    <= mpic_pkg::P_W'(pt);
        pseudorapidity <= mpic_pkg::ETA_W'(eta);
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sent++;
        gap = (calm || $urandom_range(0, 9) < 6) ? 0 : stall_len();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Stop offering and wait until every outstanding result has arrived
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (checked < sent)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Random muon, biased towards zero and extreme d0, extreme pt and eta bin boundaries
    task automatic random_muon(output int d0, output int pt, output int eta);
        int boundary;
        case ($urandom_range(0, 9))
            0:       d0 = 0;
            1, 2:    d0 = int'($urandom_range(0, 8190)) - 4095;
            3:       d0 = $urandom_range(0, 1) ? 131071 : -131072;
            default: d0 = int'($urandom_range(0, 262143)) - 131072;
        endcase
        case ($urandom_range(0, 9))
            0:       pt = 0;
            1:       pt = 65535;
            2, 3:    pt = $urandom_range(0, 2000);
            default: pt = $urandom_range(0, 65535);
        endcase
        case ($urandom_range(0, 9))
            0, 1:
            begin
                boundary = ($urandom_range(0, 1) ? 460 : 870) + int'($urandom_range(0, 1));
                eta = $urandom_range(0, 1) ? -boundary : boundary;
            end
            2:       eta = $urandom_range(0, 1) ? 2047 : -2048;
            default: eta = int'($urandom_range(0, 4095)) - 2048;
        endcase
    endtask

    initial
    begin : stimulus
        int          d0;
        int          pt;
        int          eta;
        logic [1:0]  per;
        logic [1:0]  spot;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        impact_signed  = '0;
        momentum_in    = '0;
        pseudorapidity = '0;
        cfg_write      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        calm           = 1'b0;
        hold_asks      = 0;
        sent           = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: 2018 fit mode, field extremes, bin boundaries, tanh range, clipping
        set_mode(mpic_pkg::PERIOD_2018, 2'd0);
        offer_muon(0, 40000, 100);
        offer_muon(131071, 65535, 0);
        offer_muon(-131072, 65535, -2048);
        offer_muon(1, 1, 460);
        offer_muon(-1, 65535, 461);
        offer_muon(5000, 6400, 870);
        offer_muon(-5000, 6400, 871);
        offer_muon(3000, 12800, -460);
        offer_muon(-3000, 12800, -461);
        offer_muon(7000, 32000, -870);
        offer_muon(-7000, 32000, -871);
        offer_muon(20000, 20000, 2047);
        offer_muon(-20000, 20000, -2048);
        offer_muon(100, 64000, 0);
        offer_muon(6000, 0, 300);
        offer_muon(65536, 65535, 1000);
        offer_muon(-65536, 65535, 600);
        offer_muon(1000, 65535, 0);
        offer_muon(-131071, 1, 0);
        offer_muon(131071, 0, 2047);
        drain();

        // Random phases: every period with both modes first, then random settings
        for (int ph = 0; ph < PHASES; ph++)
        begin
            if (ph < 8)
            begin
                per  = 2'(ph % 4);
                spot = {1'($urandom_range(0, 1)), 1'(ph / 4)};
            end
            else
            begin
                per  = 2'($urandom_range(0, 3));
                spot = 2'($urandom_range(0, 3));
            end
            set_mode(per, spot);
            calm = (ph == 2 || ph == 9);
            if (ph == 2)
                hold_asks++;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (ph == 6 && n == PHASE_ITEMS / 2)
                    drain();
                random_muon(d0, pt, eta);
                offer_muon(d0, pt, eta);
            end
            drain();
            calm = 1'b0;
        end

        repeat (SETTLE) @(posedge clk);
        if (fails == 0 && leftover == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

>>> files.f
rtl/core/mpic_pkg.sv
rtl/core/mpic_front.sv
rtl/core/mpic_tanh_rom.sv
rtl/core/mpic_tanh.sv
rtl/core/mpic_scale.sv
rtl/core/muon_pt_impact_correction.sv
tb/pt_correction_checker.sv
tb/tb.sv
